// File: hw/rtl/two_wire_frame_writer_macros.svh
// Assertion macros for the two-wire frame writer checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef TWO_WIRE_FRAME_WRITER_MACROS_SVH
`define TWO_WIRE_FRAME_WRITER_MACROS_SVH

// Property holds at every clock edge outside reset.
`define TWFW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition never holds at any clock edge outside reset.
`define TWFW_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/twfw_pkg.sv
// Shared types and constants of the two-wire frame writer.
// No dependencies; used by the request interface, the engine, the top module and the testbench.
package twfw_pkg;

  localparam int unsigned ByteBits  = 8;
  localparam int unsigned FrameBits = 2 * ByteBits;
  localparam int unsigned CountW    = $clog2(FrameBits + 1);

  typedef struct packed {
    logic                cmd;
    logic [ByteBits-1:0] first_byte;
    logic [ByteBits-1:0] second_byte;
    logic                sda_in;
  } twfw_item_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic sda_drive;
    logic busy_res;
    logic frame_done;
    logic refused;
  } twfw_res_t;

  localparam int unsigned ItemW = $bits(twfw_item_t);
  localparam int unsigned ResW  = $bits(twfw_res_t);

endpackage

// File: hw/rtl/twfw_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on twfw_pkg for field widths.
interface twfw_req_if import twfw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [ByteBits-1:0] first_byte;
  logic [ByteBits-1:0] second_byte;
  logic                sda_in;

  modport source (output valid, cmd, first_byte, second_byte, sda_in, input ready);
  modport sink   (input valid, cmd, first_byte, second_byte, sda_in, output ready);
endinterface

interface twfw_res_if;
  logic valid;
  logic ready;
  logic scl_level;
  logic sda_level;
  logic sda_drive;
  logic busy_res;
  logic frame_done;
  logic refused;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, frame_done,
                  refused, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, frame_done,
                  refused, output ready);
endinterface

// File: hw/rtl/twfw_pipe_reg.sv
// One-entry valid/ready pipeline register.
// No dependencies; used for the request and result stages.
module twfw_pipe_reg #(
  parameter int unsigned Width = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  logic             valid_q;
  logic [Width-1:0] data_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

endmodule

// File: hw/rtl/twfw_engine.sv
// Bus phase sequencer: frame shift state, line levels, one step per request.
// Depends on twfw_pkg for item and result types.
module twfw_engine import twfw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  twfw_item_t item_i,
  output twfw_res_t  res_o
);

  typedef enum logic [3:0] {
    PhIdle,
    PhBitLow,
    PhBitHigh,
    PhAckLow,
    PhAckHigh,
    PhAckWait,
    PhStopSda0,
    PhStopScl1,
    PhStopSda1
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [FrameBits-1:0] shift_q, shift_d;
  logic [CountW-1:0]    left_q, left_d, left_dec;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  logic                 drv_q, drv_d;
  logic                 done;
  logic                 refused;

  assign left_dec = left_q - CountW'(1);

  always_comb begin
    phase_d = phase_q;
    shift_d = shift_q;
    left_d  = left_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    drv_d   = drv_q;
    done    = 1'b0;
    refused = 1'b0;
    if (item_i.cmd) begin
      if (phase_q != PhIdle) begin
        refused = 1'b1;
      end else begin
        shift_d = {item_i.first_byte, item_i.second_byte};
        left_d  = CountW'(FrameBits);
        scl_d   = 1'b1;
        sda_d   = 1'b0;
        drv_d   = 1'b1;
        phase_d = PhBitLow;
      end
    end else begin
      case (phase_q)
        PhIdle: begin
        end
        PhBitLow: begin
          scl_d   = 1'b0;
          drv_d   = 1'b1;
          sda_d   = shift_q[FrameBits-1];
          phase_d = PhBitHigh;
        end
        PhBitHigh: begin
          scl_d   = 1'b1;
          shift_d = {shift_q[FrameBits-2:0], 1'b0};
          left_d  = left_dec;
          phase_d = (left_dec == CountW'(ByteBits) || left_dec == '0) ? PhAckLow : PhBitLow;
        end
        PhAckLow: begin
          scl_d   = 1'b0;
          drv_d   = 1'b0;
          phase_d = PhAckHigh;
        end
        PhAckHigh: begin
          scl_d   = 1'b1;
          phase_d = PhAckWait;
        end
        PhAckWait: begin
          if (!item_i.sda_in) begin
            scl_d   = 1'b0;
            drv_d   = 1'b1;
            phase_d = (left_q == '0) ? PhStopSda0 : PhBitLow;
          end
        end
        PhStopSda0: begin
          sda_d   = 1'b0;
          drv_d   = 1'b1;
          phase_d = PhStopScl1;
        end
        PhStopScl1: begin
          scl_d   = 1'b1;
          phase_d = PhStopSda1;
        end
        PhStopSda1: begin
          sda_d   = 1'b1;
          done    = 1'b1;
          phase_d = PhIdle;
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  always_comb begin
    res_o.scl_level  = scl_d;
    res_o.sda_level  = sda_d;
    res_o.sda_drive  = drv_d;
    res_o.busy_res   = (phase_d != PhIdle);
    res_o.frame_done = done;
    res_o.refused    = refused;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      shift_q <= '0;
      left_q  <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drv_q   <= 1'b1;
    end else if (fire_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      left_q  <= left_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      drv_q   <= drv_d;
    end
  end

endmodule

// File: hw/rtl/two_wire_frame_writer.sv
// Two-wire bus master writing a frame of two bytes, one bus phase per request.
// Takes one request per clock cycle while the result side is not stalled; a
// request goes through the request register, the phase engine and then the
// result register. Stalls on the result side back up into the request side
// without losing or repeating any request.
// Depends on twfw_pkg, twfw_if, twfw_pipe_reg and twfw_engine.
module two_wire_frame_writer import twfw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  twfw_req_if.sink   req_i,
  twfw_res_if.source res_o
);

  twfw_item_t in_item;
  twfw_item_t stage_item;
  logic [ItemW-1:0] stage_bits;
  logic       stage_valid;
  logic       stage_ready;
  logic       out_ready;
  twfw_res_t  step_res;
  twfw_res_t  out_res;
  logic [ResW-1:0] out_bits;

  assign in_item.cmd         = req_i.cmd;
  assign in_item.first_byte  = req_i.first_byte;
  assign in_item.second_byte = req_i.second_byte;
  assign in_item.sda_in      = req_i.sda_in;

  twfw_pipe_reg #(
    .Width (ItemW)
  ) u_req_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_data_i   (in_item),
    .out_valid_o (stage_valid),
    .out_ready_i (stage_ready),
    .out_data_o  (stage_bits)
  );

  assign stage_item = twfw_item_t'(stage_bits);

  twfw_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (stage_valid && stage_ready),
    .item_i (stage_item),
    .res_o  (step_res)
  );

  assign out_ready = res_o.ready;

  twfw_pipe_reg #(
    .Width (ResW)
  ) u_res_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stage_valid),
    .in_ready_o  (stage_ready),
    .in_data_i   (step_res),
    .out_valid_o (res_o.valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_bits)
  );

  assign out_res          = twfw_res_t'(out_bits);
  assign res_o.scl_level  = out_res.scl_level;
  assign res_o.sda_level  = out_res.sda_level;
  assign res_o.sda_drive  = out_res.sda_drive;
  assign res_o.busy_res   = out_res.busy_res;
  assign res_o.frame_done = out_res.frame_done;
  assign res_o.refused    = out_res.refused;

endmodule

// File: hw/rtl/twfw_checker.sv
// Port-level assertions for the two-wire frame writer, bound to the top level.
// Depends on two_wire_frame_writer_macros.svh and two_wire_frame_writer.
`include "two_wire_frame_writer_macros.svh"

module twfw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic scl_level_i,
  input logic sda_level_i,
  input logic sda_drive_i,
  input logic busy_res_i,
  input logic frame_done_i,
  input logic refused_i
);

  `TWFW_ASSERT(a_res_hold, clk_i, rst_ni, (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable({scl_level_i, sda_level_i, sda_drive_i, busy_res_i, frame_done_i, refused_i})), "result changed while stalled")
  `TWFW_ASSERT_NEVER(a_done_refused, clk_i, rst_ni, res_valid_i && frame_done_i && refused_i, "frame end and refusal together")
  `TWFW_ASSERT(a_done_idle, clk_i, rst_ni, (res_valid_i && frame_done_i) |-> (!busy_res_i && scl_level_i && sda_level_i && sda_drive_i), "frame end without stop levels")
  `TWFW_ASSERT_NEVER(a_release_busy, clk_i, rst_ni, res_valid_i && !sda_drive_i && !busy_res_i, "data line released while idle")

endmodule

bind two_wire_frame_writer twfw_checker u_twfw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .scl_level_i  (res_o.scl_level),
  .sda_level_i  (res_o.sda_level),
  .sda_drive_i  (res_o.sda_drive),
  .busy_res_i   (res_o.busy_res),
  .frame_done_i (res_o.frame_done),
  .refused_i    (res_o.refused)
);

// File: verif/two_wire_frame_writer_tb.sv
// Self-checking testbench of the two-wire frame writer, driven over its request channel.
// Predicts every bus phase, checks each result in order, and idles both sides in bursts.
// Depends on twfw_pkg, twfw_if and the two_wire_frame_writer RTL.
`timescale 1ns / 100ps

module two_wire_frame_writer_tb;
  import twfw_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomGoal  = 300;
  localparam int unsigned SettleTicks = 8;

  typedef enum logic [3:0] {
    BUS_IDLE,
    BIT_SETUP,
    BIT_CLOCK,
    ACK_SETUP,
    ACK_CLOCK,
    ACK_WAIT,
    STOP_SETUP,
    STOP_CLOCK,
    STOP_RELEASE
  } bus_phase_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  twfw_req_if req_if ();
  twfw_res_if res_if ();

  two_wire_frame_writer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always #5 clk = ~clk;

  bus_phase_e           bus_phase = BUS_IDLE;
  logic [FrameBits-1:0] frame_bits = '0;
  logic [CountW-1:0]    bits_to_go = '0;
  logic                 scl_q = 1'b1;
  logic                 sda_q = 1'b1;
  logic                 drive_q = 1'b1;

  twfw_res_t levels_due[$];

  bit          idle_on = 1'b1;
  int unsigned fails = 0;
  int unsigned n_requests = 0;
  int unsigned n_results = 0;
  int unsigned n_frames = 0;
  int unsigned n_refused = 0;
  int unsigned n_ack_miss = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;

  function automatic twfw_res_t bus_step(input twfw_item_t it);
    twfw_res_t r;
    r.frame_done = 1'b0;
    r.refused    = 1'b0;
    if (it.cmd) begin
      if (bus_phase != BUS_IDLE) begin
        r.refused = 1'b1;
      end else begin
        frame_bits = {it.first_byte, it.second_byte};
        bits_to_go = CountW'(FrameBits);
        scl_q      = 1'b1;
        sda_q      = 1'b0;
        drive_q    = 1'b1;
        bus_phase  = BIT_SETUP;
      end
    end else begin
      case (bus_phase)
        BUS_IDLE: begin
        end
        BIT_SETUP: begin
          scl_q     = 1'b0;
          drive_q   = 1'b1;
          sda_q     = frame_bits[FrameBits-1];
          bus_phase = BIT_CLOCK;
        end
        BIT_CLOCK: begin
          scl_q      = 1'b1;
          frame_bits = frame_bits << 1;
          bits_to_go = bits_to_go - 1'b1;
          bus_phase  = (bits_to_go == ByteBits || bits_to_go == 0) ? ACK_SETUP : BIT_SETUP;
        end
        ACK_SETUP: begin
          scl_q     = 1'b0;
          drive_q   = 1'b0;
          bus_phase = ACK_CLOCK;
        end
        ACK_CLOCK: begin
          scl_q     = 1'b1;
          bus_phase = ACK_WAIT;
        end
        ACK_WAIT: begin
          if (!it.sda_in) begin
            scl_q     = 1'b0;
            drive_q   = 1'b1;
            bus_phase = (bits_to_go == 0) ? STOP_SETUP : BIT_SETUP;
          end
        end
        STOP_SETUP: begin
          sda_q     = 1'b0;
          drive_q   = 1'b1;
          bus_phase = STOP_CLOCK;
        end
        STOP_CLOCK: begin
          scl_q     = 1'b1;
          bus_phase = STOP_RELEASE;
        end
        STOP_RELEASE: begin
          sda_q        = 1'b1;
          r.frame_done = 1'b1;
          bus_phase    = BUS_IDLE;
        end
        default: begin
          bus_phase = BUS_IDLE;
        end
      endcase
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.sda_drive = drive_q;
    r.busy_res  = (bus_phase != BUS_IDLE);
    return r;
  endfunction

  task automatic send_request(input twfw_item_t it);
    int unsigned gap;
    if (idle_on && $urandom_range(5) == 0) begin
      gap = $urandom_range(6, 1);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.cmd         <= it.cmd;
    req_if.first_byte  <= it.first_byte;
    req_if.second_byte <= it.second_byte;
    req_if.sda_in      <= it.sda_in;
    do @(posedge clk); while (!req_if.ready);
    if (it.cmd && bus_phase != BUS_IDLE) n_refused++;
    else if (it.cmd) n_frames++;
    levels_due.push_back(bus_step(it));
    n_requests++;
  endtask

  task automatic send_tick(input logic sda);
    twfw_item_t it;
    it.cmd         = 1'b0;
    it.first_byte  = ByteBits'($urandom_range(255));
    it.second_byte = ByteBits'($urandom_range(255));
    it.sda_in      = sda;
    send_request(it);
  endtask

  task automatic send_start(input logic [ByteBits-1:0] b1, input logic [ByteBits-1:0] b2);
    twfw_item_t it;
    it.cmd         = 1'b1;
    it.first_byte  = b1;
    it.second_byte = b2;
    it.sda_in      = 1'($urandom_range(1));
    send_request(it);
  endtask

  // Hold SDA high for miss_req ticks of every ack wait, then acknowledge.
  task automatic finish_frame(input int unsigned miss_req, input bit noisy);
    int unsigned misses;
    misses = 0;
    while (bus_phase != BUS_IDLE) begin
      if (noisy && $urandom_range(15) == 0) begin
        send_start(ByteBits'($urandom_range(255)), ByteBits'($urandom_range(255)));
      end else if (bus_phase == ACK_WAIT) begin
        if (misses < miss_req) begin
          send_tick(1'b1);
          misses++;
          n_ack_miss++;
        end else begin
          send_tick(1'b0);
          misses = 0;
        end
      end else begin
        send_tick(1'($urandom_range(1)));
      end
    end
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (levels_due.size() != 0);
  endtask

  task automatic check_bit(input string name, input logic exp, input logic act);
    if (act !== exp) begin
      $error("%s: expected %0b, got %0b", name, exp, act);
      fails++;
    end
  endtask

  task automatic test_idle_ticks();
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_edge_frame();
    send_start(8'hFF, 8'h00);
    send_start(8'h00, 8'hFF);
    finish_frame(1, 1'b0);
  endtask

  task automatic test_drain_mid_frame();
    send_start(ByteBits'($urandom_range(255)), ByteBits'($urandom_range(255)));
    repeat (5) send_tick(1'($urandom_range(1)));
    drain_results();
    finish_frame(0, 1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned k;
    goal = n_requests + RandomGoal;
    while (n_requests < goal) begin
      if ($urandom_range(4) != 0) begin
        send_start(ByteBits'($urandom_range(255)), ByteBits'($urandom_range(255)));
        finish_frame($urandom_range(3), 1'b1);
      end else begin
        k = $urandom_range(4, 1);
        repeat (k) send_tick(1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (2) begin
      send_start(ByteBits'($urandom_range(255)), ByteBits'($urandom_range(255)));
      finish_frame($urandom_range(1), 1'b1);
    end
  endtask

  always @(posedge clk) begin
    if (!idle_on) begin
      res_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(5) == 0) begin
      res_if.ready <= 1'b0;
      stall_left = $urandom_range(5);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    twfw_res_t exp;
    if (rst_n && res_if.valid && res_if.ready) begin
      n_results++;
      if (levels_due.size() == 0) begin
        $error("result with no pending request");
        fails++;
      end else begin
        exp = levels_due.pop_front();
        check_bit("scl_level", exp.scl_level, res_if.scl_level);
        check_bit("sda_level", exp.sda_level, res_if.sda_level);
        check_bit("sda_drive", exp.sda_drive, res_if.sda_drive);
        check_bit("busy_res", exp.busy_res, res_if.busy_res);
        check_bit("frame_done", exp.frame_done, res_if.frame_done);
        check_bit("refused", exp.refused, res_if.refused);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("two_wire_frame_writer: mismatch");
      $finish;
    end
  end

  initial begin
    req_if.valid       = 1'b0;
    req_if.cmd         = 1'b0;
    req_if.first_byte  = '0;
    req_if.second_byte = '0;
    req_if.sda_in      = 1'b0;
    res_if.ready       = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_edge_frame();
    test_drain_mid_frame();
    test_random_traffic();
    test_back_to_back();

    req_if.valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (SettleTicks) @(posedge clk);

    $display("Sent %0d requests: %0d frames, %0d refused sends, %0d missed acks.",
             n_requests, n_frames, n_refused, n_ack_miss);
    $display("Checked %0d results, %0d field mismatches.", n_results, fails);
    if (fails == 0) begin
      $display("two_wire_frame_writer: match");
    end else begin
      $display("two_wire_frame_writer: mismatch");
    end
    $finish;
  end

endmodule
